// File: hw/rtl/bfs_pkg.sv
package bfs_pkg;

	// line and store dimensions
	localparam int MAX_LINE    = 512;
	localparam int ORDER_DEPTH = 256;
	localparam int ORDER_AW    = $clog2(ORDER_DEPTH);
	localparam int LEN_W       = $clog2(MAX_LINE + 1);

	typedef logic [7:0]          char_t;
	typedef logic [9:0]          count_t;
	typedef logic [ORDER_AW:0]   idx_t;
	typedef logic [ORDER_AW-1:0] addr_t;
	typedef logic [LEN_W-1:0]    len_t;

	localparam count_t COUNT_MAX = '1;

	// line terminators
	localparam char_t CHAR_NUL = 8'd0;
	localparam char_t CHAR_NL  = 8'd10;

	// request codes
	typedef enum logic {
		FUNC_ADD  = 1'b0,
		FUNC_READ = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_UPD,
		ST_RD_CNT,
		ST_RD_OUT,
		ST_RD_EMPTY
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic add_start;
		logic add_upd;
		logic rd_start;
		logic rd_cnt;
		logic rd_load;
		logic empty_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic add_go;
		logic rd_empty;
		logic out_free;
	} status_t;

endpackage

// File: hw/rtl/bfs_if.sv
interface bfs_in_if;
	logic           valid;
	logic           ready;
	logic           func;
	bfs_pkg::char_t char_in;

	modport source (output valid, output func, output char_in, input ready);
	modport sink (input valid, input func, input char_in, output ready);
endinterface

interface bfs_out_if;
	logic            valid;
	logic            ready;
	logic            entry_valid;
	bfs_pkg::char_t  char_out;
	bfs_pkg::count_t occurrences;
	logic            is_last;

	modport source (output valid, output entry_valid, output char_out, output occurrences,
		output is_last, input ready);
	modport sink (input valid, input entry_valid, input char_out, input occurrences,
		input is_last, output ready);
endinterface

// File: hw/rtl/bfs_ctrl.sv
module bfs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             func,
	input  bfs_pkg::status_t st,
	output logic             in_ready,
	output bfs_pkg::cmd_t    cmd
);
	import bfs_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = in_valid && in_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_ADD) begin
						if (st.add_go) state_d = ST_ADD_UPD;
					end else if (st.rd_empty) begin
						state_d = ST_RD_EMPTY;
					end else begin
						state_d = ST_RD_CNT;
					end
				end
			end
			ST_ADD_UPD:  state_d = ST_IDLE;
			ST_RD_CNT:   state_d = ST_RD_OUT;
			ST_RD_OUT:   if (st.out_free) state_d = ST_IDLE;
			ST_RD_EMPTY: if (st.out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready       = (state_q == ST_IDLE);
		cmd            = '0;
		cmd.add_start  = accept && (func == FUNC_ADD);
		cmd.rd_start   = accept && (func == FUNC_READ) && !st.rd_empty;
		cmd.add_upd    = (state_q == ST_ADD_UPD);
		cmd.rd_cnt     = (state_q == ST_RD_CNT);
		cmd.rd_load    = (state_q == ST_RD_OUT) && st.out_free;
		cmd.empty_load = (state_q == ST_RD_EMPTY) && st.out_free;
	end

endmodule

// File: hw/rtl/bfs_dp.sv
module bfs_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  bfs_pkg::cmd_t    cmd,
	output bfs_pkg::status_t st,
	input  bfs_pkg::char_t   char_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             entry_valid,
	output bfs_pkg::char_t   char_out,
	output bfs_pkg::count_t  occurrences,
	output logic             is_last
);
	import bfs_pkg::*;

	// stores
	count_t count_mem [ORDER_DEPTH];
	char_t  order_mem [ORDER_DEPTH];
	logic [ORDER_DEPTH-1:0] cnt_vld_q;

	idx_t   distinct_q;
	idx_t   rp_q;
	len_t   len_q;
	logic   closed_q;
	char_t  char_q;
	char_t  ord_rd_q;
	count_t cnt_rd_q;
	logic   cnt_vld_rd_q;
	logic   out_vld_q;
	logic   ent_vld_q;
	char_t  char_out_q;
	count_t occ_q;
	logic   last_q;

	logic   is_term;
	logic   cnt_re;
	char_t  cnt_raddr;
	count_t cnt_cur;
	count_t cnt_next;
	logic   new_char;
	logic   last_w;
	logic   finish;

	assign is_term  = (char_in == CHAR_NUL) || (char_in == CHAR_NL);
	assign cnt_cur  = cnt_vld_rd_q ? cnt_rd_q : '0;
	assign cnt_next = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + count_t'(1);
	assign new_char = (cnt_cur == '0) && (distinct_q < idx_t'(ORDER_DEPTH));
	assign last_w   = ((rp_q + idx_t'(1)) == distinct_q);
	assign finish   = cmd.empty_load || (cmd.rd_load && last_w);
	assign cnt_re   = cmd.add_start || cmd.rd_cnt;
	assign cnt_raddr = cmd.add_start ? char_in : ord_rd_q;

	// status to controller
	always_comb begin
		st.add_go   = !closed_q && !is_term && (len_q < len_t'(MAX_LINE));
		st.rd_empty = (distinct_q == '0) || (rp_q >= distinct_q);
		st.out_free = !out_vld_q || out_ready;
	end

	// line and readout bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distinct_q <= '0;
			rp_q       <= '0;
			len_q      <= '0;
			closed_q   <= 1'b0;
			cnt_vld_q  <= '0;
		end else if (finish) begin
			distinct_q <= '0;
			rp_q       <= '0;
			len_q      <= '0;
			closed_q   <= 1'b0;
			cnt_vld_q  <= '0;
		end else begin
			if (cmd.add_start && !closed_q) begin
				if (is_term) begin
					closed_q <= 1'b1;
				end else if (len_q < len_t'(MAX_LINE)) begin
					len_q <= len_q + len_t'(1);
				end
			end
			if (cmd.add_upd) begin
				cnt_vld_q[char_q] <= 1'b1;
				if (new_char) distinct_q <= distinct_q + idx_t'(1);
			end
			if (cmd.rd_load) rp_q <= rp_q + idx_t'(1);
		end
	end

	// count memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.add_upd) count_mem[char_q] <= cnt_next;
		if (cnt_re) begin
			cnt_rd_q     <= count_mem[cnt_raddr];
			cnt_vld_rd_q <= cnt_vld_q[cnt_raddr];
		end
	end

	// order list memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.add_upd && new_char) order_mem[distinct_q[ORDER_AW-1:0]] <= char_q;
		if (cmd.rd_start) ord_rd_q <= order_mem[rp_q[ORDER_AW-1:0]];
	end

	// byte held for the count update
	always_ff @(posedge clk) begin
		if (cmd.add_start) char_q <= char_in;
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.rd_load || cmd.empty_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.rd_load) begin
			ent_vld_q  <= 1'b1;
			char_out_q <= ord_rd_q;
			occ_q      <= cnt_cur;
			last_q     <= last_w;
		end else if (cmd.empty_load) begin
			ent_vld_q  <= 1'b0;
			char_out_q <= '0;
			occ_q      <= '0;
			last_q     <= 1'b0;
		end
	end

	assign out_valid   = out_vld_q;
	assign entry_valid = ent_vld_q;
	assign char_out    = char_out_q;
	assign occurrences = occ_q;
	assign is_last     = last_q;

endmodule

// File: hw/rtl/byte_frequency_first_seen_order.sv
// Byte histogram of one text line, reported in first-seen order. An add request
// (func 0) counts one byte; byte 0 or 10 closes the line and later adds are dropped
// until the line is read out, and bytes past the first 512 are dropped too. A read
// request (func 1) returns the next distinct byte with its count and flags the last
// one; returning the last entry (or reading with nothing stored, which gives a
// result with entry_valid low) clears the histogram for a new line. One request is
// handled at a time: an add that is dropped or closes the line is done on acceptance,
// a counted add reads then writes the single-port count memory, and a read does the
// order list read, count read and result load in turn, or only the result load when
// nothing is stored, and a result load waits until the previous result has been
// taken. Counts are cleared at once through a per-byte valid vector, so no clearing
// pass follows reset or readout.
module byte_frequency_first_seen_order (
	input logic        clk,
	input logic        arst_n,
	bfs_in_if.sink     in_ch,
	bfs_out_if.source  out_ch
);
	import bfs_pkg::*;

	cmd_t    cmd;
	status_t st;

	// sequencer
	bfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.func     (in_ch.func),
		.st       (st),
		.in_ready (in_ch.ready),
		.cmd      (cmd)
	);

	// stores and result register
	bfs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.char_in     (in_ch.char_in),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.entry_valid (out_ch.entry_valid),
		.char_out    (out_ch.char_out),
		.occurrences (out_ch.occurrences),
		.is_last     (out_ch.is_last)
	);

endmodule

// File: hw/rtl/bfs_chk.sv
module bfs_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            func,
	input logic            out_valid,
	input logic            out_ready,
	input logic            entry_valid,
	input bfs_pkg::char_t  char_out,
	input bfs_pkg::count_t occurrences,
	input logic            is_last
);
	import bfs_pkg::*;

	// a result waits until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before taken");

	// a read request keeps the block busy in the next cycle
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == FUNC_READ) |=> !in_ready)
		else $error("request taken during read");

	// an empty result carries all-zero fields
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_valid |-> (char_out == '0) && (occurrences == '0) && !is_last)
		else $error("empty result with nonzero fields");

	// a returned byte was counted at least once
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_valid |-> (occurrences != '0))
		else $error("returned entry with zero count");

endmodule

bind byte_frequency_first_seen_order bfs_chk u_bfs_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.func        (in_ch.func),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.entry_valid (out_ch.entry_valid),
	.char_out    (out_ch.char_out),
	.occurrences (out_ch.occurrences),
	.is_last     (out_ch.is_last)
);

// File: verif/byte_frequency_first_seen_order_tb.sv
module byte_frequency_first_seen_order_tb;
	import bfs_pkg::*;

	localparam int RAND_ITEMS = 650;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_LINE = MAX_LINE + 8;

	// one result of a read request
	typedef struct packed {
		logic   entry_valid;
		char_t  ch;
		count_t occ;
		logic   last;
	} line_entry_t;

	// one directed request, with its result typed in when pin is set
	typedef struct packed {
		func_t       f;
		char_t       c;
		logic        pin;
		line_entry_t res;
	} stim_row_t;

	localparam line_entry_t NO_ENTRY = '0;

	logic clk;
	logic arst_n;

	bfs_in_if  in_ch ();
	bfs_out_if out_ch ();

	byte_frequency_first_seen_order dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// histogram shadow state
	count_t hist_cnt [256];
	char_t  first_seen [256];
	idx_t   n_distinct;
	idx_t   rd_idx;
	len_t   line_len;
	logic   line_done;

	line_entry_t entry_q [$];
	logic        pin_now;
	line_entry_t pin_res;
	int          errors = 0;
	int          cycles = 0;
	int          sent = 0;
	bit          quiet = 0;

	// directed requests: extremes, terminators, dropped adds, empty reads
	stim_row_t dir_rows [24] = '{
		'{FUNC_READ, 8'h00, 1'b1, NO_ENTRY},
		'{FUNC_ADD,  8'hFF, 1'b0, NO_ENTRY},
		'{FUNC_ADD,  8'hFF, 1'b0, NO_ENTRY},
		'{FUNC_ADD,  8'h01, 1'b0, NO_ENTRY},
		'{FUNC_ADD,  CHAR_NL, 1'b0, NO_ENTRY},
		'{FUNC_ADD,  8'h41, 1'b0, NO_ENTRY},
		'{FUNC_READ, 8'hFF, 1'b1, '{1'b1, 8'hFF, 10'd2, 1'b0}},
		'{FUNC_READ, 8'h00, 1'b1, '{1'b1, 8'h01, 10'd1, 1'b1}},
		'{FUNC_READ, 8'h00, 1'b1, NO_ENTRY},
		'{FUNC_ADD,  8'h80, 1'b0, NO_ENTRY},
		'{FUNC_READ, 8'h00, 1'b1, '{1'b1, 8'h80, 10'd1, 1'b1}},
		'{FUNC_ADD,  8'h7F, 1'b0, NO_ENTRY},
		'{FUNC_ADD,  CHAR_NUL, 1'b0, NO_ENTRY},
		'{FUNC_ADD,  8'h7F, 1'b0, NO_ENTRY},
		'{FUNC_READ, 8'h00, 1'b1, '{1'b1, 8'h7F, 10'd1, 1'b1}},
		'{FUNC_ADD,  CHAR_NUL, 1'b0, NO_ENTRY},
		'{FUNC_READ, 8'hAA, 1'b1, NO_ENTRY},
		'{FUNC_ADD,  8'h55, 1'b0, NO_ENTRY},
		'{FUNC_ADD,  8'hAA, 1'b0, NO_ENTRY},
		'{FUNC_ADD,  8'h55, 1'b0, NO_ENTRY},
		'{FUNC_READ, 8'h00, 1'b1, '{1'b1, 8'h55, 10'd2, 1'b0}},
		'{FUNC_ADD,  8'hAA, 1'b0, NO_ENTRY},
		'{FUNC_READ, 8'h00, 1'b0, NO_ENTRY},
		'{FUNC_READ, 8'h00, 1'b1, NO_ENTRY}
	};

	// clear the histogram for a new line
	function automatic void clear_line();
		for (int i = 0; i < 256; i++) begin
			hist_cnt[i] = '0;
		end
		n_distinct = '0;
		rd_idx = '0;
		line_len = '0;
		line_done = 1'b0;
	endfunction

	// apply one request to the shadow state, returns 1 when a result is due
	function automatic bit hist_step(input func_t f, input char_t c, output line_entry_t r);
		r = NO_ENTRY;
		if (f == FUNC_ADD) begin
			if (!line_done) begin
				if (c == CHAR_NUL || c == CHAR_NL) begin
					line_done = 1'b1;
				end else if (line_len < len_t'(MAX_LINE)) begin
					line_len++;
					if (hist_cnt[c] == '0 && n_distinct < idx_t'(ORDER_DEPTH)) begin
						first_seen[n_distinct[ORDER_AW-1:0]] = c;
						n_distinct++;
					end
					if (hist_cnt[c] != COUNT_MAX)
						hist_cnt[c]++;
				end
			end
			return 1'b0;
		end
		if (n_distinct == '0 || rd_idx >= n_distinct) begin
			clear_line();
			return 1'b1;
		end
		r.entry_valid = 1'b1;
		r.ch = first_seen[rd_idx[ORDER_AW-1:0]];
		r.occ = hist_cnt[r.ch];
		r.last = (idx_t'(rd_idx + 1'b1) == n_distinct);
		if (r.last)
			clear_line();
		else
			rd_idx++;
		return 1'b1;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result checking and request prediction
	always @(posedge clk) begin
		line_entry_t want;
		line_entry_t got;
		line_entry_t pred;
		bit          due;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.entry_valid, out_ch.char_out, out_ch.occurrences, out_ch.is_last};
				if (entry_q.size() == 0) begin
					$error("result with no request pending: char_out %0h", got.ch);
					errors++;
				end else begin
					want = entry_q.pop_front();
					if (got.entry_valid !== want.entry_valid) begin
						$error("entry_valid: expected %0d, got %0d", want.entry_valid,
							got.entry_valid);
						errors++;
					end
					if (got.ch !== want.ch) begin
						$error("char_out: expected %0h, got %0h", want.ch, got.ch);
						errors++;
					end
					if (got.occ !== want.occ) begin
						$error("occurrences: expected %0d, got %0d", want.occ, got.occ);
						errors++;
					end
					if (got.last !== want.last) begin
						$error("is_last: expected %0d, got %0d", want.last, got.last);
						errors++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				due = hist_step(func_t'(in_ch.func), in_ch.char_in, pred);
				if (due)
					entry_q.push_back(pin_now ? pin_res : pred);
			end
		end
	end

	// result side stalls
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// issue one request and wait until it is taken
	task automatic send(input func_t f, input char_t c, input logic pin, input line_entry_t res);
		in_ch.valid <= 1'b1;
		in_ch.func <= f;
		in_ch.char_in <= c;
		pin_now <= pin;
		pin_res <= res;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sent++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// stimulus
	initial begin
		int    len;
		int    nreads;
		int    nd;
		bit    narrow;
		bit    closed;
		bit    seen [256];
		char_t base;
		char_t c;
		in_ch.valid <= 1'b0;
		in_ch.func <= FUNC_ADD;
		in_ch.char_in <= '0;
		pin_now <= 1'b0;
		pin_res <= NO_ENTRY;
		arst_n <= 1'b0;
		for (int i = 0; i < 256; i++) begin
			first_seen[i] = '0;
		end
		clear_line();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send(dir_rows[i].f, dir_rows[i].c, dir_rows[i].pin, dir_rows[i].res);

		// overlong line of one byte: the count tops out at the line limit
		repeat (LONG_LINE) send(FUNC_ADD, 8'hC3, 1'b0, NO_ENTRY);
		send(FUNC_ADD, CHAR_NL, 1'b0, NO_ENTRY);
		send(FUNC_READ, 8'h00, 1'b1, '{1'b1, 8'hC3, count_t'(MAX_LINE), 1'b1});
		send(FUNC_READ, 8'h00, 1'b1, NO_ENTRY);

		// random short lines, mostly terminated and read out in full
		while (sent < RAND_ITEMS) begin
			quiet = (sent > RAND_ITEMS * 85 / 100);
			len = $urandom_range(0, 24);
			narrow = $urandom_range(0, 1);
			base = char_t'($urandom_range(0, 255));
			closed = 1'b0;
			nd = 0;
			for (int i = 0; i < 256; i++) begin
				seen[i] = 1'b0;
			end
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 11) == 0)
					send(FUNC_READ, char_t'($urandom_range(0, 255)), 1'b0, NO_ENTRY);
				c = narrow ? char_t'(base + $urandom_range(0, 3)) : char_t'($urandom_range(0, 255));
				send(FUNC_ADD, c, 1'b0, NO_ENTRY);
				if (c == CHAR_NUL || c == CHAR_NL) begin
					closed = 1'b1;
				end else if (!closed && !seen[c]) begin
					seen[c] = 1'b1;
					nd++;
				end
			end
			if ($urandom_range(0, 4) != 0)
				send(FUNC_ADD, $urandom_range(0, 1) ? CHAR_NUL : CHAR_NL, 1'b0, NO_ENTRY);
			// extra adds, dropped when the line is closed
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 3))
					send(FUNC_ADD, char_t'($urandom_range(0, 255)), 1'b0, NO_ENTRY);
			nreads = nd + $urandom_range(0, 1);
			if ($urandom_range(0, 7) == 0)
				nreads = $urandom_range(0, nd);
			repeat (nreads) send(FUNC_READ, char_t'($urandom_range(0, 255)), 1'b0, NO_ENTRY);
		end

		in_ch.valid <= 1'b0;
		while (entry_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
